// ===== hw/rtl/mtep_pkg.sv =====
package mtep_pkg;

  localparam int MaxLengthGroups = 4;
  localparam int ValueW = 28;
  localparam int GroupCountW = 3;

  localparam logic [7:0] DATA_MASK = 8'h7f;
  localparam logic [7:0] STATUS_MIN = 8'h80;
  localparam logic [7:0] HIGH_MASK = 8'hf0;
  localparam logic [7:0] LOW_MASK = 8'h0f;
  localparam logic [7:0] STATUS_SYSEX = 8'hf0;
  localparam logic [7:0] STATUS_ESCAPE = 8'hf7;
  localparam logic [7:0] STATUS_META = 8'hff;
  localparam logic [7:0] META_END_OF_TRACK = 8'h2f;
  localparam logic [3:0] HI_CHANNEL_LAST = 4'he;
  localparam logic [3:0] HI_PROGRAM = 4'hc;
  localparam logic [3:0] HI_PRESSURE = 4'hd;

  localparam logic [1:0] KIND_CHANNEL = 2'd0;
  localparam logic [1:0] KIND_HEADER = 2'd1;
  localparam logic [1:0] KIND_PAYLOAD = 2'd2;
  localparam logic [1:0] KIND_ERROR = 2'd3;

  localparam logic [1:0] ERR_NONE = 2'd0;
  localparam logic [1:0] ERR_TOO_LONG = 2'd1;
  localparam logic [1:0] ERR_UNKNOWN_STATUS = 2'd2;
  localparam logic [1:0] ERR_AFTER_END = 2'd3;

  typedef enum logic [6:0] {
    PH_DELTA    = 7'b0000001,
    PH_STATUS   = 7'b0000010,
    PH_PARAM1   = 7'b0000100,
    PH_PARAM2   = 7'b0001000,
    PH_METATYPE = 7'b0010000,
    PH_LENGTH   = 7'b0100000,
    PH_PAYLOAD  = 7'b1000000
  } phase_t;

  typedef struct packed {
    logic       track_start;
    logic [7:0] data_byte;
  } item_t;

  typedef struct packed {
    logic [1:0]        record_kind;
    logic [ValueW-1:0] delta_ticks;
    logic [7:0]        status;
    logic [3:0]        channel;
    logic [7:0]        param_one;
    logic [7:0]        param_two;
    logic [7:0]        meta_kind;
    logic [ValueW-1:0] payload_length;
    logic [7:0]        payload_value;
    logic              last_of_event;
    logic              track_ended;
    logic [1:0]        error_code;
  } result_t;

endpackage

// ===== hw/rtl/mtep_in_reg.sv =====
module mtep_in_reg (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  output logic            s_tready,
  input  mtep_pkg::item_t s_item,
  output logic            valid,
  output mtep_pkg::item_t item,
  input  logic            advance
);

  assign s_tready = !valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (s_tready) begin
      valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      item <= s_item;
    end
  end

endmodule

// ===== hw/rtl/mtep_core.sv =====
module mtep_core #(
  parameter int MAX_LENGTH_GROUPS = mtep_pkg::MaxLengthGroups
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,
  input  mtep_pkg::item_t   item,
  output logic              res_valid,
  output mtep_pkg::result_t res
);

  localparam int VW = mtep_pkg::ValueW;
  localparam int GW = mtep_pkg::GroupCountW;

  mtep_pkg::phase_t phase, phase_next;
  logic [7:0]    running_status, running_status_next;
  logic [7:0]    current_status, current_status_next;
  logic [VW-1:0] delta_acc, delta_acc_next;
  logic [GW-1:0] group_count, group_count_next;
  logic [7:0]    first_param, first_param_next;
  logic [7:0]    meta_type, meta_type_next;
  logic [VW-1:0] length_acc, length_acc_next;
  logic [VW-1:0] bytes_remaining, bytes_remaining_next;
  logic          ended_flag, ended_flag_next;
  logic          error_flag, error_flag_next;

  logic [7:0]    b;
  logic          is_data;
  logic          do_body;
  logic [3:0]    hi;
  logic [GW-1:0] gc_inc;
  logic          vlq_done;
  logic          vlq_over;
  logic [VW-1:0] vlq_acc;
  logic          finish;

  assign b = item.data_byte;
  assign is_data = (b & mtep_pkg::STATUS_MIN) == 8'h00;

  always_comb begin
    phase_next = phase;
    running_status_next = running_status;
    current_status_next = current_status;
    delta_acc_next = delta_acc;
    group_count_next = group_count;
    first_param_next = first_param;
    meta_type_next = meta_type;
    length_acc_next = length_acc;
    bytes_remaining_next = bytes_remaining;
    ended_flag_next = ended_flag;
    error_flag_next = error_flag;
    res = '0;
    res_valid = 1'b0;
    do_body = 1'b0;
    finish = 1'b0;
    hi = '0;
    gc_inc = '0;
    vlq_done = 1'b0;
    vlq_over = 1'b0;
    vlq_acc = '0;

    if (item.track_start) begin
      running_status_next = '0;
      current_status_next = '0;
      ended_flag_next = 1'b0;
      error_flag_next = 1'b0;
      phase_next = mtep_pkg::PH_DELTA;
      delta_acc_next = '0;
      group_count_next = '0;
      first_param_next = '0;
      meta_type_next = '0;
      length_acc_next = '0;
      bytes_remaining_next = '0;
    end

    if (error_flag_next) begin
      // locked until the next track start
    end else if (ended_flag_next) begin
      res_valid = 1'b1;
      res.record_kind = mtep_pkg::KIND_ERROR;
      res.error_code = mtep_pkg::ERR_AFTER_END;
      error_flag_next = 1'b1;
    end else if (phase_next == mtep_pkg::PH_STATUS) begin
      if (!is_data) begin
        running_status_next = b;
      end
      current_status_next = running_status_next;
      hi = current_status_next[7:4];
      if (hi >= mtep_pkg::STATUS_MIN[7:4] && hi <= mtep_pkg::HI_CHANNEL_LAST) begin
        phase_next = mtep_pkg::PH_PARAM1;
        do_body = is_data;
      end else if (current_status_next == mtep_pkg::STATUS_SYSEX ||
                   current_status_next == mtep_pkg::STATUS_ESCAPE) begin
        meta_type_next = '0;
        length_acc_next = '0;
        group_count_next = '0;
        phase_next = mtep_pkg::PH_LENGTH;
        do_body = is_data;
      end else if (current_status_next == mtep_pkg::STATUS_META) begin
        phase_next = mtep_pkg::PH_METATYPE;
        do_body = is_data;
      end else begin
        res_valid = 1'b1;
        res.record_kind = mtep_pkg::KIND_ERROR;
        res.error_code = mtep_pkg::ERR_UNKNOWN_STATUS;
        error_flag_next = 1'b1;
      end
    end else begin
      do_body = 1'b1;
    end

    if (do_body) begin
      // variable-length group, applied to whichever accumulator is live
      gc_inc = group_count_next + GW'(1);
      vlq_done = is_data;
      vlq_over = !is_data && (gc_inc >= GW'(MAX_LENGTH_GROUPS));
      vlq_acc = (phase_next == mtep_pkg::PH_LENGTH) ? length_acc_next : delta_acc_next;
      vlq_acc = {vlq_acc[VW-8:0], b[6:0]};

      unique case (phase_next)
        mtep_pkg::PH_PARAM1: begin
          first_param_next = b;
          if (current_status_next[7:4] == mtep_pkg::HI_PROGRAM ||
              current_status_next[7:4] == mtep_pkg::HI_PRESSURE) begin
            res_valid = 1'b1;
            res.record_kind = mtep_pkg::KIND_CHANNEL;
            res.delta_ticks = delta_acc_next;
            res.status = current_status_next;
            res.channel = current_status_next[3:0];
            res.param_one = b;
            res.last_of_event = 1'b1;
            finish = 1'b1;
          end else begin
            phase_next = mtep_pkg::PH_PARAM2;
          end
        end
        mtep_pkg::PH_PARAM2: begin
          res_valid = 1'b1;
          res.record_kind = mtep_pkg::KIND_CHANNEL;
          res.delta_ticks = delta_acc_next;
          res.status = current_status_next;
          res.channel = current_status_next[3:0];
          res.param_one = first_param_next;
          res.param_two = b;
          res.last_of_event = 1'b1;
          finish = 1'b1;
        end
        mtep_pkg::PH_METATYPE: begin
          meta_type_next = b;
          length_acc_next = '0;
          group_count_next = '0;
          phase_next = mtep_pkg::PH_LENGTH;
        end
        mtep_pkg::PH_LENGTH: begin
          length_acc_next = vlq_acc;
          group_count_next = vlq_done ? '0 : gc_inc;
          if (vlq_over) begin
            res_valid = 1'b1;
            res.record_kind = mtep_pkg::KIND_ERROR;
            res.error_code = mtep_pkg::ERR_TOO_LONG;
            error_flag_next = 1'b1;
          end else if (vlq_done) begin
            res_valid = 1'b1;
            res.record_kind = mtep_pkg::KIND_HEADER;
            res.delta_ticks = delta_acc_next;
            res.status = current_status_next;
            res.meta_kind = (current_status_next == mtep_pkg::STATUS_META) ?
                            meta_type_next : 8'h00;
            res.payload_length = vlq_acc;
            bytes_remaining_next = vlq_acc;
            if (vlq_acc == '0) begin
              finish = 1'b1;
            end else begin
              phase_next = mtep_pkg::PH_PAYLOAD;
            end
          end
        end
        mtep_pkg::PH_PAYLOAD: begin
          res_valid = 1'b1;
          res.record_kind = mtep_pkg::KIND_PAYLOAD;
          res.delta_ticks = delta_acc_next;
          res.status = current_status_next;
          res.meta_kind = (current_status_next == mtep_pkg::STATUS_META) ?
                          meta_type_next : 8'h00;
          res.payload_length = length_acc_next;
          res.payload_value = b;
          bytes_remaining_next = bytes_remaining_next - VW'(1);
          finish = (bytes_remaining_next == '0);
        end
        default: begin
          delta_acc_next = vlq_acc;
          group_count_next = vlq_done ? '0 : gc_inc;
          if (vlq_over) begin
            res_valid = 1'b1;
            res.record_kind = mtep_pkg::KIND_ERROR;
            res.error_code = mtep_pkg::ERR_TOO_LONG;
            error_flag_next = 1'b1;
          end else if (vlq_done) begin
            phase_next = mtep_pkg::PH_STATUS;
          end
        end
      endcase

      if (finish) begin
        res.last_of_event = 1'b1;
        if (res.record_kind != mtep_pkg::KIND_CHANNEL &&
            current_status_next == mtep_pkg::STATUS_META &&
            meta_type_next == mtep_pkg::META_END_OF_TRACK) begin
          res.track_ended = 1'b1;
          ended_flag_next = 1'b1;
        end
        phase_next = mtep_pkg::PH_DELTA;
        delta_acc_next = '0;
        group_count_next = '0;
        first_param_next = '0;
        meta_type_next = '0;
        length_acc_next = '0;
        bytes_remaining_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= mtep_pkg::PH_DELTA;
      running_status <= '0;
      current_status <= '0;
      delta_acc <= '0;
      group_count <= '0;
      first_param <= '0;
      meta_type <= '0;
      length_acc <= '0;
      bytes_remaining <= '0;
      ended_flag <= 1'b0;
      error_flag <= 1'b0;
    end else if (fire) begin
      phase <= phase_next;
      running_status <= running_status_next;
      current_status <= current_status_next;
      delta_acc <= delta_acc_next;
      group_count <= group_count_next;
      first_param <= first_param_next;
      meta_type <= meta_type_next;
      length_acc <= length_acc_next;
      bytes_remaining <= bytes_remaining_next;
      ended_flag <= ended_flag_next;
      error_flag <= error_flag_next;
    end
  end

  a_locked_silent: assert property (@(posedge clk) disable iff (rst)
    (error_flag && !item.track_start) |-> !res_valid)
    else $error("result produced while locked after error");

  a_error_locks: assert property (@(posedge clk) disable iff (rst)
    (fire && res_valid && res.record_kind == mtep_pkg::KIND_ERROR) |=> error_flag)
    else $error("error record did not set the lock");

  a_channel_last: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.record_kind == mtep_pkg::KIND_CHANNEL) |->
      (res.last_of_event && phase_next == mtep_pkg::PH_DELTA))
    else $error("channel record did not close the event");

  a_end_sets_flag: assert property (@(posedge clk) disable iff (rst)
    (fire && res_valid && res.track_ended) |=> (ended_flag && phase == mtep_pkg::PH_DELTA))
    else $error("end of track not recorded");

endmodule

// ===== hw/rtl/mtep_out_reg.sv =====
module mtep_out_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  mtep_pkg::result_t res,
  output logic              free,
  output logic              m_tvalid,
  input  logic              m_tready,
  output mtep_pkg::result_t m_res
);

  assign free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_res <= res;
    end
  end

endmodule

// ===== hw/rtl/midi_track_event_parser.sv =====
// MIDI track event parser.
// Slave channel: one track-body byte per request; tdata = data_byte,
// tuser = track_start (set on the first byte of a new track).
// Master channel: at most one event record per input byte. tlast marks the
// final record of an event; tuser carries record_kind and track_ended.
// Path: a byte accepted into the input register is decoded combinationally
// from that register, and its record is loaded into the output register
// when the decode fires, so each record passes through the input and then
// the output register before it appears on the master port.
// Throughput: one byte per cycle while tready stays high, set by the
// combinational decode between the input and result registers.
// Reset clears the parse state, running status and error lock, and empties
// both registers. When the receiver holds tready low, the held record stays
// on the master port; the decoder stops, the input register keeps one byte
// and s_tready drops, so no byte or record is lost.
// After an error record the block emits nothing until a track_start byte.
module midi_track_event_parser #(
  parameter int MAX_LENGTH_GROUPS = mtep_pkg::MaxLengthGroups
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [7:0]   s_tdata,   // [7:0] data_byte
  input  logic         s_tuser,   // [0] track_start
  output logic         m_tvalid,
  input  logic         m_tready,
  // [27:0] delta_ticks, [35:28] status, [39:36] channel, [47:40] param_one,
  // [55:48] param_two, [63:56] meta_kind, [91:64] payload_length,
  // [99:92] payload_value, [101:100] error_code, [103:102] zero
  output logic [103:0] m_tdata,
  output logic         m_tlast,   // last_of_event
  output logic [2:0]   m_tuser    // [1:0] record_kind, [2] track_ended
);

  mtep_pkg::item_t   s_item;
  mtep_pkg::item_t   item;
  mtep_pkg::result_t res;
  mtep_pkg::result_t m_res;
  logic              item_valid;
  logic              res_valid;
  logic              out_free;
  logic              fire;

  assign s_item.track_start = s_tuser;
  assign s_item.data_byte = s_tdata;
  assign fire = item_valid && out_free;

  mtep_in_reg u_in (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_item   (s_item),
    .valid    (item_valid),
    .item     (item),
    .advance  (fire)
  );

  mtep_core #(
    .MAX_LENGTH_GROUPS (MAX_LENGTH_GROUPS)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .item      (item),
    .res_valid (res_valid),
    .res       (res)
  );

  mtep_out_reg u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (fire && res_valid),
    .res      (res),
    .free     (out_free),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_res    (m_res)
  );

  assign m_tdata = {2'b00, m_res.error_code, m_res.payload_value, m_res.payload_length,
                    m_res.meta_kind, m_res.param_two, m_res.param_one, m_res.channel,
                    m_res.status, m_res.delta_ticks};
  assign m_tlast = m_res.last_of_event;
  assign m_tuser = {m_res.track_ended, m_res.record_kind};

endmodule
